// ===== design/sgpf_pkg.sv =====
package sgpf_pkg;

	// field widths
	localparam int MASS_W  = 16;
	localparam int MM_W    = 2 * MASS_W;
	localparam int FORCE_W = 48;
	localparam int GC_W    = 24;
	localparam int MIND_W  = 19;
	localparam int KS_W    = 10;
	localparam int K2_W    = 2 * KS_W;
	localparam int K3_W    = 3 * KS_W;
	localparam int GK_W    = GC_W + K3_W;

	// quotient bits kept by the divider
	localparam int QW = FORCE_W;

	// register file
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REG_GRAV_CONST     = 2'd0,
		REG_MIN_DISTANCE   = 2'd1,
		REG_DISTANCE_SCALE = 2'd2,
		REG_NONE           = 2'd3
	} reg_idx_t;

	localparam logic [GC_W-1:0]   GRAV_CONST_RST     = 24'd437125;
	localparam logic [MIND_W-1:0] MIN_DISTANCE_RST   = 19'd5120;
	localparam logic [KS_W-1:0]   DISTANCE_SCALE_RST = 10'd75;

	localparam logic [FORCE_W:0] FORCE_POS_LIMIT = {2'b00, {(FORCE_W-1){1'b1}}};
	localparam logic [FORCE_W:0] FORCE_NEG_LIMIT = {2'b01, {(FORCE_W-1){1'b0}}};

endpackage

// ===== design/softened_gravity_pair_force_unit.sv =====
// Softened 2D gravitational pair force.
// Item channel: item_valid / item_stall carry two body positions (signed Q11.8)
// and two masses (Q8.8); a beat is taken when item_valid is high and
// item_stall is low. Result channel: result_valid / result_stall carry the
// force on body a (signed Q31.16, saturated), the clamp flag and the
// saturation flag, one result beat per item beat, in order.
// The pipeline has four front stages, one square-root stage per root bit,
// four stages that clamp and build numerator and denominator, an overflow
// check, one divider stage per quotient bit (48) and the output register.
// It takes one item per cycle unless stalled; every stage holds its own
// data, so beats follow back to back. When result_stall is high while a
// result is shown, the whole pipeline holds and item_stall rises in the
// same cycle; nothing is dropped. Reset clears all valid bits and loads
// the register defaults (G = 6.67, min distance = 20.0, scale = 75).
// Registers are written over APB at byte addresses 0, 4 and 8; the user
// must write them only while no item is in flight; the block never checks.
module softened_gravity_pair_force_unit #(
	parameter int POSITION_WIDTH = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sgpf_pkg::APB_AW-1:0]         paddr,
	input  logic [sgpf_pkg::APB_DW-1:0]         pwdata,
	output logic [sgpf_pkg::APB_DW-1:0]         prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic signed [POSITION_WIDTH-1:0]    pos_a_x,
	input  logic signed [POSITION_WIDTH-1:0]    pos_a_y,
	input  logic signed [POSITION_WIDTH-1:0]    pos_b_x,
	input  logic signed [POSITION_WIDTH-1:0]    pos_b_y,
	input  logic [sgpf_pkg::MASS_W-1:0]         mass_a,
	input  logic [sgpf_pkg::MASS_W-1:0]         mass_b,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [sgpf_pkg::FORCE_W-1:0] force_x,
	output logic signed [sgpf_pkg::FORCE_W-1:0] force_y,
	output logic                                distance_clamped,
	output logic                                saturated
);
	import sgpf_pkg::*;

	localparam int P    = POSITION_WIDTH;
	localparam int DXW  = P + 1;
	localparam int SW   = 2 * P + 2;
	localparam int NSQ  = P + 1;
	localparam int RTW  = P + 1;
	localparam int DW   = (RTW > MIND_W) ? RTW : MIND_W;
	localparam int P1W  = MM_W + DXW;
	localparam int P1L  = P1W / 2;
	localparam int P1H  = P1W - P1L;
	localparam int GKL  = GK_W / 2;
	localparam int GKH  = GK_W - GKL;
	localparam int NUMW = P1W + GK_W;
	localparam int DENW = 3 * DW;
	localparam int DVW  = (NUMW > DENW + QW) ? NUMW : DENW + QW;
	localparam int LAT  = NSQ + QW + 10;

	// configuration registers
	logic [GC_W-1:0]   grav_const_q;
	logic [MIND_W-1:0] min_distance_q;
	logic [KS_W-1:0]   distance_scale_q;
	reg_idx_t          widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_const_q     <= GRAV_CONST_RST;
			min_distance_q   <= MIN_DISTANCE_RST;
			distance_scale_q <= DISTANCE_SCALE_RST;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_GRAV_CONST:     grav_const_q     <= pwdata[GC_W-1:0];
				REG_MIN_DISTANCE:   min_distance_q   <= pwdata[MIND_W-1:0];
				REG_DISTANCE_SCALE: distance_scale_q <= pwdata[KS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_GRAV_CONST:     prdata = APB_DW'(grav_const_q);
			REG_MIN_DISTANCE:   prdata = APB_DW'(min_distance_q);
			REG_DISTANCE_SCALE: prdata = APB_DW'(distance_scale_q);
			default:            prdata = '0;
		endcase
	end

	// zero min-distance and distance-scale values act as one
	logic [KS_W-1:0]   k_eff;
	logic [MIND_W-1:0] mind_eff;
	assign k_eff    = (distance_scale_q == '0) ? KS_W'(1) : distance_scale_q;
	assign mind_eff = (min_distance_q == '0) ? MIND_W'(1) : min_distance_q;

	// global advance: hold everything while a shown result is stalled
	logic           en;
	logic [LAT-1:0] vld_s;

	assign en           = !(vld_s[LAT-1] && result_stall);
	assign item_stall   = !en;
	assign result_valid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], item_valid};
		end
	end

	// stage 1: differences, mass product, k^2
	logic [DXW-1:0]  dx_s1, dy_s1;
	logic [MM_W-1:0] mm_s1;
	logic [K2_W-1:0] k2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {pos_b_x[P-1], pos_b_x} - {pos_a_x[P-1], pos_a_x};
			dy_s1 <= {pos_b_y[P-1], pos_b_y} - {pos_a_y[P-1], pos_a_y};
			mm_s1 <= MM_W'(mass_a) * MM_W'(mass_b);
			k2_s1 <= K2_W'(k_eff) * K2_W'(k_eff);
		end
	end

	// stage 2: magnitudes, k^3
	logic [DXW-1:0]  ax_s2, ay_s2;
	logic            negx_s2, negy_s2;
	logic [MM_W-1:0] mm_s2;
	logic [K3_W-1:0] k3_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			negx_s2 <= dx_s1[DXW-1];
			negy_s2 <= dy_s1[DXW-1];
			ax_s2   <= dx_s1[DXW-1] ? (~dx_s1 + DXW'(1)) : dx_s1;
			ay_s2   <= dy_s1[DXW-1] ? (~dy_s1 + DXW'(1)) : dy_s1;
			mm_s2   <= mm_s1;
			k3_s2   <= K3_W'(k2_s1) * K3_W'(k_eff);
		end
	end

	// stage 3: squares, G*k^3, mass product times magnitude
	logic [SW-1:0]   sqx_s3, sqy_s3;
	logic [GK_W-1:0] gk_s3;
	logic [P1W-1:0]  p1x_s3, p1y_s3;
	logic            negx_s3, negy_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3  <= SW'(ax_s2) * SW'(ax_s2);
			sqy_s3  <= SW'(ay_s2) * SW'(ay_s2);
			gk_s3   <= GK_W'(grav_const_q) * GK_W'(k3_s2);
			p1x_s3  <= P1W'(mm_s2) * P1W'(ax_s2);
			p1y_s3  <= P1W'(mm_s2) * P1W'(ay_s2);
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
		end
	end

	// stage 4 feeds the square root: entry 0 of the root arrays
	logic [SW-1:0]   sq_rem_s5  [0:NSQ];
	logic [RTW-1:0]  sq_root_s5 [0:NSQ];
	logic [P1W-1:0]  sq_p1x_s5  [0:NSQ];
	logic [P1W-1:0]  sq_p1y_s5  [0:NSQ];
	logic [GK_W-1:0] sq_gk_s5   [0:NSQ];
	logic            sq_negx_s5 [0:NSQ];
	logic            sq_negy_s5 [0:NSQ];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s5[0]  <= sqx_s3 + sqy_s3;
			sq_root_s5[0] <= '0;
			sq_p1x_s5[0]  <= p1x_s3;
			sq_p1y_s5[0]  <= p1y_s3;
			sq_gk_s5[0]   <= gk_s3;
			sq_negx_s5[0] <= negx_s3;
			sq_negy_s5[0] <= negy_s3;
		end
	end

	// floor square root, one root bit per stage, remainder kept as n - root^2
	for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
		localparam int B = P - j;
		logic [SW-1:0] trial;

		assign trial = (SW'(sq_root_s5[j]) << (B + 1)) + (SW'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (sq_rem_s5[j] >= trial) begin
					sq_rem_s5[j+1]  <= sq_rem_s5[j] - trial;
					sq_root_s5[j+1] <= sq_root_s5[j] | (RTW'(1) << B);
				end else begin
					sq_rem_s5[j+1]  <= sq_rem_s5[j];
					sq_root_s5[j+1] <= sq_root_s5[j];
				end
				sq_p1x_s5[j+1]  <= sq_p1x_s5[j];
				sq_p1y_s5[j+1]  <= sq_p1y_s5[j];
				sq_gk_s5[j+1]   <= sq_gk_s5[j];
				sq_negx_s5[j+1] <= sq_negx_s5[j];
				sq_negy_s5[j+1] <= sq_negy_s5[j];
			end
		end
	end

	// stage 6: clamp, numerator partial products
	logic [DW-1:0]      root_len;
	logic [P1W-1:0]     p1x, p1y;
	logic [GK_W-1:0]    gk;
	logic [DW-1:0]      dc_s6;
	logic               clamp_s6, negx_s6, negy_s6;
	logic [P1L+GKL-1:0] ppx00_s6, ppy00_s6;
	logic [P1L+GKH-1:0] ppx01_s6, ppy01_s6;
	logic [P1H+GKL-1:0] ppx10_s6, ppy10_s6;
	logic [P1H+GKH-1:0] ppx11_s6, ppy11_s6;

	assign root_len = DW'(sq_root_s5[NSQ]);
	assign p1x      = sq_p1x_s5[NSQ];
	assign p1y      = sq_p1y_s5[NSQ];
	assign gk       = sq_gk_s5[NSQ];

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s6 <= root_len < DW'(mind_eff);
			dc_s6    <= (root_len < DW'(mind_eff)) ? DW'(mind_eff) : root_len;
			negx_s6  <= sq_negx_s5[NSQ];
			negy_s6  <= sq_negy_s5[NSQ];
			ppx00_s6 <= (P1L+GKL)'(p1x[P1L-1:0]) * (P1L+GKL)'(gk[GKL-1:0]);
			ppx01_s6 <= (P1L+GKH)'(p1x[P1L-1:0]) * (P1L+GKH)'(gk[GK_W-1:GKL]);
			ppx10_s6 <= (P1H+GKL)'(p1x[P1W-1:P1L]) * (P1H+GKL)'(gk[GKL-1:0]);
			ppx11_s6 <= (P1H+GKH)'(p1x[P1W-1:P1L]) * (P1H+GKH)'(gk[GK_W-1:GKL]);
			ppy00_s6 <= (P1L+GKL)'(p1y[P1L-1:0]) * (P1L+GKL)'(gk[GKL-1:0]);
			ppy01_s6 <= (P1L+GKH)'(p1y[P1L-1:0]) * (P1L+GKH)'(gk[GK_W-1:GKL]);
			ppy10_s6 <= (P1H+GKL)'(p1y[P1W-1:P1L]) * (P1H+GKL)'(gk[GKL-1:0]);
			ppy11_s6 <= (P1H+GKH)'(p1y[P1W-1:P1L]) * (P1H+GKH)'(gk[GK_W-1:GKL]);
		end
	end

	// stage 7: numerators, dc^2
	logic [NUMW-1:0] numx_s7, numy_s7;
	logic [2*DW-1:0] dc2_s7;
	logic [DW-1:0]   dc_s7;
	logic            clamp_s7, negx_s7, negy_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s7  <= NUMW'(ppx00_s6) + (NUMW'(ppx01_s6) << GKL)
				+ (NUMW'(ppx10_s6) << P1L) + (NUMW'(ppx11_s6) << (P1L + GKL));
			numy_s7  <= NUMW'(ppy00_s6) + (NUMW'(ppy01_s6) << GKL)
				+ (NUMW'(ppy10_s6) << P1L) + (NUMW'(ppy11_s6) << (P1L + GKL));
			dc2_s7   <= (2*DW)'(dc_s6) * (2*DW)'(dc_s6);
			dc_s7    <= dc_s6;
			clamp_s7 <= clamp_s6;
			negx_s7  <= negx_s6;
			negy_s7  <= negy_s6;
		end
	end

	// stage 8: dc^3 partial products
	logic [2*DW-1:0] denl_s8, denh_s8;
	logic [NUMW-1:0] numx_s8, numy_s8;
	logic            clamp_s8, negx_s8, negy_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			denl_s8  <= (2*DW)'(dc2_s7[DW-1:0]) * (2*DW)'(dc_s7);
			denh_s8  <= (2*DW)'(dc2_s7[2*DW-1:DW]) * (2*DW)'(dc_s7);
			numx_s8  <= numx_s7;
			numy_s8  <= numy_s7;
			clamp_s8 <= clamp_s7;
			negx_s8  <= negx_s7;
			negy_s8  <= negy_s7;
		end
	end

	// stage 9: denominator
	logic [DENW-1:0] den_s9;
	logic [NUMW-1:0] numx_s9, numy_s9;
	logic            clamp_s9, negx_s9, negy_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s9   <= DENW'(denl_s8) + (DENW'(denh_s8) << DW);
			numx_s9  <= numx_s8;
			numy_s9  <= numy_s8;
			clamp_s9 <= clamp_s8;
			negx_s9  <= negx_s8;
			negy_s9  <= negy_s8;
		end
	end

	// stage 10 feeds the divider: quotient too wide for 48 bits flags overflow
	logic [DVW-1:0]  dv_remx_s10 [0:QW];
	logic [DVW-1:0]  dv_remy_s10 [0:QW];
	logic [QW-1:0]   dv_qx_s10   [0:QW];
	logic [QW-1:0]   dv_qy_s10   [0:QW];
	logic [DENW-1:0] dv_den_s10  [0:QW];
	logic            dv_ovfx_s10 [0:QW];
	logic            dv_ovfy_s10 [0:QW];
	logic            dv_negx_s10 [0:QW];
	logic            dv_negy_s10 [0:QW];
	logic            dv_clamp_s10 [0:QW];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_remx_s10[0]  <= DVW'(numx_s9);
			dv_remy_s10[0]  <= DVW'(numy_s9);
			dv_qx_s10[0]    <= '0;
			dv_qy_s10[0]    <= '0;
			dv_den_s10[0]   <= den_s9;
			dv_ovfx_s10[0]  <= DVW'(numx_s9) >= (DVW'(den_s9) << QW);
			dv_ovfy_s10[0]  <= DVW'(numy_s9) >= (DVW'(den_s9) << QW);
			dv_negx_s10[0]  <= negx_s9;
			dv_negy_s10[0]  <= negy_s9;
			dv_clamp_s10[0] <= clamp_s9;
		end
	end

	// restoring division, one quotient bit per stage, MSB first
	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int B = QW - 1 - i;
		logic [DVW-1:0] dsh;

		assign dsh = DVW'(dv_den_s10[i]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (dv_remx_s10[i] >= dsh) begin
					dv_remx_s10[i+1] <= dv_remx_s10[i] - dsh;
					dv_qx_s10[i+1]   <= dv_qx_s10[i] | (QW'(1) << B);
				end else begin
					dv_remx_s10[i+1] <= dv_remx_s10[i];
					dv_qx_s10[i+1]   <= dv_qx_s10[i];
				end
				if (dv_remy_s10[i] >= dsh) begin
					dv_remy_s10[i+1] <= dv_remy_s10[i] - dsh;
					dv_qy_s10[i+1]   <= dv_qy_s10[i] | (QW'(1) << B);
				end else begin
					dv_remy_s10[i+1] <= dv_remy_s10[i];
					dv_qy_s10[i+1]   <= dv_qy_s10[i];
				end
				dv_den_s10[i+1]   <= dv_den_s10[i];
				dv_ovfx_s10[i+1]  <= dv_ovfx_s10[i];
				dv_ovfy_s10[i+1]  <= dv_ovfy_s10[i];
				dv_negx_s10[i+1]  <= dv_negx_s10[i];
				dv_negy_s10[i+1]  <= dv_negy_s10[i];
				dv_clamp_s10[i+1] <= dv_clamp_s10[i];
			end
		end
	end

	// output stage: saturate, apply sign
	logic [FORCE_W:0]   limx, limy, qx, qy, vx, vy;
	logic               satx, saty;
	logic [FORCE_W-1:0] force_x_q, force_y_q;
	logic               clamp_q, sat_q;

	assign qx   = (FORCE_W+1)'(dv_qx_s10[QW]);
	assign qy   = (FORCE_W+1)'(dv_qy_s10[QW]);
	assign limx = dv_negx_s10[QW] ? FORCE_NEG_LIMIT : FORCE_POS_LIMIT;
	assign limy = dv_negy_s10[QW] ? FORCE_NEG_LIMIT : FORCE_POS_LIMIT;
	assign satx = dv_ovfx_s10[QW] || (qx > limx);
	assign saty = dv_ovfy_s10[QW] || (qy > limy);
	assign vx   = satx ? limx : qx;
	assign vy   = saty ? limy : qy;

	always_ff @(posedge clk) begin
		if (en) begin
			force_x_q <= dv_negx_s10[QW] ? (~vx[FORCE_W-1:0] + FORCE_W'(1)) : vx[FORCE_W-1:0];
			force_y_q <= dv_negy_s10[QW] ? (~vy[FORCE_W-1:0] + FORCE_W'(1)) : vy[FORCE_W-1:0];
			clamp_q   <= dv_clamp_s10[QW];
			sat_q     <= satx || saty;
		end
	end

	assign force_x          = force_x_q;
	assign force_y          = force_y_q;
	assign distance_clamped = clamp_q;
	assign saturated        = sat_q;

endmodule

// ===== design/sgpf_checker.sv =====
module sgpf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                pready,
	input logic                                item_valid,
	input logic                                item_stall,
	input logic                                result_valid,
	input logic                                result_stall,
	input logic signed [sgpf_pkg::FORCE_W-1:0] force_x,
	input logic signed [sgpf_pkg::FORCE_W-1:0] force_y,
	input logic                                distance_clamped,
	input logic                                saturated
);
	import sgpf_pkg::*;

	localparam logic [FORCE_W-1:0] FMAX = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic [FORCE_W-1:0] FMIN = {1'b1, {(FORCE_W-1){1'b0}}};

	// the pipeline only holds when a shown result is refused
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (result_valid && result_stall))
		else $error("item_stall not tied to a refused result beat");

	// a saturated beat shows a limit value on one component
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
			(force_x == FMAX || force_x == FMIN || force_y == FMAX || force_y == FMIN))
		else $error("saturated beat without a limit value");

	// a refused result beat is held unchanged
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(force_x) &&
			$stable(force_y) && $stable(distance_clamped) && $stable(saturated))
		else $error("refused result beat changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind softened_gravity_pair_force_unit sgpf_checker u_sgpf_checker (.*);

// ===== dv/force_checker.sv =====
`timescale 1ns / 100ps

module force_checker
	import sgpf_pkg::*;
#(
	parameter int PW = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [APB_AW-1:0]           paddr,
	input  logic [APB_DW-1:0]           pwdata,
	input  logic                        item_valid,
	input  logic                        item_stall,
	input  logic signed [PW-1:0]        pos_a_x,
	input  logic signed [PW-1:0]        pos_a_y,
	input  logic signed [PW-1:0]        pos_b_x,
	input  logic signed [PW-1:0]        pos_b_y,
	input  logic [MASS_W-1:0]           mass_a,
	input  logic [MASS_W-1:0]           mass_b,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  logic signed [FORCE_W-1:0]   force_x,
	input  logic signed [FORCE_W-1:0]   force_y,
	input  logic                        distance_clamped,
	input  logic                        saturated,
	output int                          fail_count,
	output int                          pending
);

	typedef struct packed {
		logic [FORCE_W-1:0] fx;
		logic [FORCE_W-1:0] fy;
		logic               clamped;
		logic               sat;
	} pair_force_t;

	pair_force_t expected_forces[$];
	logic [GC_W-1:0]   g_reg;
	logic [MIND_W-1:0] mind_reg;
	logic [KS_W-1:0]   scale_reg;

	function automatic logic [63:0] floor_sqrt(logic [63:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n) r = t;
		end
		return r;
	endfunction

	function automatic logic [FORCE_W-1:0] force_axis(longint d, logic [127:0] gmm,
			logic [127:0] k3, logic [127:0] den, inout logic sat);
		logic [127:0] mag;
		logic [127:0] q;
		logic [127:0] lim;
		logic [127:0] v;
		mag = (d < 0) ? 128'(-d) : 128'(d);
		q = (gmm * mag * k3) / den;
		lim = (d < 0) ? (128'd1 << 47) : ((128'd1 << 47) - 1);
		if (q > lim) begin
			sat = 1'b1;
			v = lim;
		end else begin
			v = q;
		end
		if (d < 0) v = -v;
		return v[FORCE_W-1:0];
	endfunction

	function automatic pair_force_t predict_pair_force(longint ax_, longint ay_, longint bx,
			longint by, logic [MASS_W-1:0] ma, logic [MASS_W-1:0] mb);
		pair_force_t r;
		longint dx, dy;
		logic [63:0] ux, uy, sep, mind, k, dc;
		logic [127:0] gmm, k3, den;
		dx = bx - ax_;
		dy = by - ay_;
		ux = (dx < 0) ? -dx : dx;
		uy = (dy < 0) ? -dy : dy;
		sep = floor_sqrt(ux * ux + uy * uy);
		// zero min-distance and scale values behave as one
		mind = (mind_reg == 0) ? 64'd1 : 64'(mind_reg);
		k = (scale_reg == 0) ? 64'd1 : 64'(scale_reg);
		r.clamped = sep < mind;
		dc = r.clamped ? mind : sep;
		gmm = 128'(g_reg) * 128'(ma) * 128'(mb);
		k3 = 128'(k) * 128'(k) * 128'(k);
		den = 128'(dc) * 128'(dc) * 128'(dc);
		r.sat = 1'b0;
		r.fx = force_axis(dx, gmm, k3, den, r.sat);
		r.fy = force_axis(dy, gmm, k3, den, r.sat);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [FORCE_W-1:0] got,
			logic [FORCE_W-1:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending = expected_forces.size();

	always @(posedge clk or negedge arst_n) begin
		pair_force_t e;
		if (!arst_n) begin
			g_reg = GRAV_CONST_RST;
			mind_reg = MIN_DISTANCE_RST;
			scale_reg = DISTANCE_SCALE_RST;
			expected_forces.delete();
			fail_count = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_forces.size() == 0) begin
					report_mismatch("unexpected beat", force_x, '0);
				end else begin
					e = expected_forces.pop_front();
					if (force_x !== e.fx) report_mismatch("force_x", force_x, e.fx);
					if (force_y !== e.fy) report_mismatch("force_y", force_y, e.fy);
					if (distance_clamped !== e.clamped)
						report_mismatch("distance_clamped", FORCE_W'(distance_clamped),
							FORCE_W'(e.clamped));
					if (saturated !== e.sat)
						report_mismatch("saturated", FORCE_W'(saturated), FORCE_W'(e.sat));
				end
			end
			if (item_valid && !item_stall)
				expected_forces.insert(expected_forces.size(),
					predict_pair_force(pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_GRAV_CONST:     g_reg = pwdata[GC_W-1:0];
					REG_MIN_DISTANCE:   mind_reg = pwdata[MIND_W-1:0];
					REG_DISTANCE_SCALE: scale_reg = pwdata[KS_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import sgpf_pkg::*;

	localparam int PW = 20;
	localparam int LATENCY = PW + 59;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic signed [PW-1:0] pos_a_x = '0, pos_a_y = '0, pos_b_x = '0, pos_b_y = '0;
	logic [MASS_W-1:0] mass_a = '0, mass_b = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [FORCE_W-1:0] force_x, force_y;
	logic distance_clamped, saturated;
	int fail_count, pending;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int beats_sent = 0;
	int hold_left = 0;
	bit hold_used = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	softened_gravity_pair_force_unit #(.POSITION_WIDTH(PW)) uut (.*);

	force_checker #(.PW(PW)) checker_i (.*);

	// receiver: random stall, plus one long hold-off to back the pipe up
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_used && beats_sent >= 700) begin
			hold_used <= 1'b1;
			hold_left <= 400;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		#(20.0 * 3000000);
		$display("FAILURE");
		$finish;
	end

	task automatic send_pair(logic [PW-1:0] ax, logic [PW-1:0] ay, logic [PW-1:0] bx,
			logic [PW-1:0] by, logic [15:0] ma, logic [15:0] mb);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		pos_a_x <= ax;
		pos_a_y <= ay;
		pos_b_x <= bx;
		pos_b_y <= by;
		mass_a <= ma;
		mass_b <= mb;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		beats_sent++;
	endtask

	task automatic drain;
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_pair;
		logic [PW-1:0] ax, ay, bx, by;
		logic [15:0] ma, mb;
		int sel;
		ax = PW'($urandom);
		ay = PW'($urandom);
		sel = $urandom_range(9);
		// mostly nearby bodies so both clamped and unclamped lengths show up
		if (sel < 4) begin
			bx = ax + PW'($signed(12'($urandom)));
			by = ay + PW'($signed(12'($urandom)));
		end else if (sel < 6) begin
			bx = ax + PW'($signed(18'($urandom)));
			by = ay + PW'($signed(18'($urandom)));
		end else if (sel == 6) begin
			bx = ax;
			by = ay;
		end else begin
			bx = PW'($urandom);
			by = PW'($urandom);
		end
		ma = 16'($urandom);
		mb = 16'($urandom);
		case ($urandom_range(7))
			0: ma = 0;
			1: mb = 16'hFFFF;
			2: ma = 16'($urandom_range(1023));
			default: ;
		endcase
		send_pair(ax, ay, bx, by, ma, mb);
	endtask

	localparam logic [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

	initial begin
		logic [31:0] cfg [6][3];
		int idle_cfg [6][2];
		cfg = '{'{437125, 5120, 75}, '{24'hFFFFFF, 19'h7FFFF, 1023},
			'{1, 0, 0}, '{24'hFFFFFF, 1, 1023}, '{0, 1, 1},
			'{32'd437125, 32'd256, 32'd3}};
		idle_cfg = '{'{0, 0}, '{81, 0}, '{0, 81}, '{34, 34}, '{0, 0}, '{81, 81}};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, coincident bodies, zero masses, axis-aligned pulls
		send_pair(0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
		send_pair(PMIN, PMIN, PMAX, PMAX, 16'hFFFF, 16'hFFFF);
		send_pair(PMAX, PMAX, PMIN, PMIN, 16'hFFFF, 16'hFFFF);
		send_pair(PMIN, PMAX, PMAX, PMIN, 16'h0100, 16'h0100);
		send_pair(0, 0, 100, 0, 16'h0100, 16'h0100);
		send_pair(0, 0, 0, -5120, 16'h0100, 16'h0100);
		send_pair(0, 0, 5120, 0, 16'h0100, 16'h0100);
		send_pair(0, 0, 5119, 0, 16'h0100, 16'h0100);
		send_pair(10, 20, 10, 20, 16'h0100, 16'h0100);
		send_pair(0, 0, 3000, 4000, 0, 16'hFFFF);
		send_pair(0, 0, 3000, 4000, 16'hFFFF, 0);
		send_pair(-1, -1, 1, 1, 16'hFFFF, 16'hFFFF);
		send_pair(PMAX, 0, PMIN, 0, 16'h0001, 16'h0001);
		send_pair(0, PMIN, 0, PMAX, 16'h8000, 16'h8000);
		send_pair(20'hAAAAA, 20'h55555, 20'h55555, 20'hAAAAA, 16'hAAAA, 16'h5555);
		send_pair(20'h55555, 20'hAAAAA, 20'hAAAAA, 20'h55555, 16'h5555, 16'hAAAA);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_GRAV_CONST, cfg[ph][0]);
			write_reg(REG_MIN_DISTANCE, cfg[ph][1]);
			write_reg(REG_DISTANCE_SCALE, cfg[ph][2]);
			send_idle_pct = idle_cfg[ph][0];
			stall_pct = idle_cfg[ph][1];
			for (int n = 0; n < 315; n++) begin
				// quiet stretch in the middle of each phase
				if (n == 150) begin
					send_idle_pct = 0;
					stall_pct = 0;
				end else if (n == 200) begin
					send_idle_pct = idle_cfg[ph][0];
					stall_pct = idle_cfg[ph][1];
				end
				random_pair();
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
